### rtl/bres_pkg.sv
// shared constants, request/pixel structs and codes for the line pixel generator
// no dependencies; used by bres_core, bres_addr and the top level
`timescale 1ns / 1ps
`default_nettype none

package bres_pkg;

    // frame buffer geometry
    localparam int BYTES_PER_ROW = 80;
    localparam int SCREEN_ROWS   = 480;
    localparam int PIX_PER_BYTE  = 8;

    // field widths
    localparam int COORD_W  = 10;
    localparam int COLOR_W  = 4;
    localparam int ERR_W    = 13;
    localparam int BIDX_W   = 16;
    localparam int MASK_W   = PIX_PER_BYTE;
    localparam int BITSEL_W = $clog2(PIX_PER_BYTE);
    localparam int BPR_W    = $clog2(BYTES_PER_ROW + 1);
    localparam int PROD_W   = COORD_W + BPR_W;
    localparam int LIM_W    = COORD_W + 1;

    // screen limits, one bit wider than a coordinate so 1024 fits
    localparam logic [LIM_W-1:0] X_LIMIT = LIM_W'(PIX_PER_BYTE * BYTES_PER_ROW);
    localparam logic [LIM_W-1:0] Y_LIMIT = LIM_W'(SCREEN_ROWS);

    // leftmost pixel sits in the msb of the byte
    localparam logic [MASK_W-1:0] MASK_MSB = MASK_W'(1) << (MASK_W - 1);

    // stream payload widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0] pen_color;
    } t_req;

    typedef struct packed {
        logic               valid_res;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } t_pix;

endpackage

`default_nettype wire

### rtl/bresenham_line_pixel_generator.sv
// top level of the line pixel generator: stream ports and the three-stage pipeline
// depends on bres_pkg, bres_core and bres_addr
`timescale 1ns / 1ps
`default_nettype none

// Bresenham line engine for a four-plane planar frame buffer. A load transaction
// (tuser 0) sets up a line and returns its start pixel; each step transaction
// (tuser 1) returns the next pixel, with the end point marked by tlast. Every
// input transaction yields exactly one output transaction; a step with no line
// active returns an all-zero payload with tuser 0. One transaction is taken per
// clock unless m_axis back-pressure stalls the pipeline, and a pixel leaves through
// the input register, pixel register and result register in turn. The rate is set
// by the error-term update loop in bres_core, which holds the line state. The whole
// pipeline advances together whenever the result register is empty or being
// taken, so s_axis tready follows m_axis tready in the same cycle.
module bresenham_line_pixel_generator (
    input  wire                                i_clk,
    input  wire                                i_rst_n,

    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // start_x[9:0], start_y[19:10], end_x[29:20], end_y[39:30], pen_color[43:40], zeros
    input  wire [bres_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // req_type[0]
    input  wire                                i_s_axis_tuser,

    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // pixel_x[9:0], pixel_y[19:10], byte_index[35:20], bit_mask[43:36],
    // pixel_color[47:44], off_screen[48], zeros
    output logic [bres_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // valid_res[0]
    output logic                               o_m_axis_tuser,
    // last
    output logic                               o_m_axis_tlast
);

    localparam int CW = bres_pkg::COORD_W;

    // pipeline enable: result register empty or being drained
    logic w_en;

    // stage 1: registered request
    logic               r_s1_valid;
    bres_pkg::t_req     r_s1_req;
    bres_pkg::t_req     w_in_req;

    // stage 2: registered pixel
    logic               r_s2_valid;
    bres_pkg::t_pix     r_s2_pix;
    bres_pkg::t_pix     w_core_pix;

    // stage 3: result register
    logic                              r_out_valid;
    logic [bres_pkg::OUT_DATA_W-1:0]   r_out_tdata;
    logic                              r_out_tuser;
    logic                              r_out_tlast;

    logic [bres_pkg::BIDX_W-1:0]       w_byte_index;
    logic [bres_pkg::MASK_W-1:0]       w_bit_mask;
    logic                              w_off_screen;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // unpack the input transaction
    always_comb begin
        w_in_req.req_type  = i_s_axis_tuser;
        w_in_req.start_x   = i_s_axis_tdata[CW-1:0];
        w_in_req.start_y   = i_s_axis_tdata[2*CW-1:CW];
        w_in_req.end_x     = i_s_axis_tdata[3*CW-1:2*CW];
        w_in_req.end_y     = i_s_axis_tdata[4*CW-1:3*CW];
        w_in_req.pen_color = i_s_axis_tdata[4*CW+bres_pkg::COLOR_W-1:4*CW];
    end

    // line state and step update, committed only when a request moves on
    bres_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_en && r_s1_valid),
        .i_req    (r_s1_req),
        .o_pix    (w_core_pix)
    );

    // frame buffer address of the registered pixel
    bres_addr u_addr (
        .i_pix        (r_s2_pix),
        .o_byte_index (w_byte_index),
        .o_bit_mask   (w_bit_mask),
        .o_off_screen (w_off_screen)
    );

    // valid bits of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= i_s_axis_tvalid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_req    <= w_in_req;
            r_s2_pix    <= w_core_pix;
            r_out_tdata <= {{(bres_pkg::OUT_DATA_W - 49){1'b0}},
                            w_off_screen,
                            r_s2_pix.pixel_color,
                            w_bit_mask,
                            w_byte_index,
                            r_s2_pix.pixel_y,
                            r_s2_pix.pixel_x};
            r_out_tuser <= r_s2_pix.valid_res;
            r_out_tlast <= r_s2_pix.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;
    assign o_m_axis_tlast  = r_out_tlast;

    // a step with no line active carries nothing but zeros
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0 && !o_m_axis_tlast))
        else $error("idle step result not all zero");

    // every emitted pixel has exactly one mask bit
    a_mask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> $onehot(o_m_axis_tdata[43:36]))
        else $error("bit mask not one-hot");

    // a load always produces a pixel in the next stage
    a_load_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_s1_valid && r_s1_req.req_type == bres_pkg::REQ_LOAD)
        |=> (r_s2_valid && r_s2_pix.valid_res))
        else $error("load did not emit a pixel");

    // the whole pipeline freezes under back-pressure
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_s1_valid) && $stable(r_s2_valid) && $stable(r_s2_pix)))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

### rtl/bres_core.sv
// line state registers and the one-step bresenham update
// depends on bres_pkg for widths, codes and the request/pixel structs
`timescale 1ns / 1ps
`default_nettype none

module bres_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_update,
    input  wire bres_pkg::t_req i_req,
    output bres_pkg::t_pix      o_pix
);

    localparam int CW = bres_pkg::COORD_W;
    localparam int EW = bres_pkg::ERR_W;

    logic [CW-1:0]                 r_cur_x, r_cur_y, r_tgt_x, r_tgt_y, r_dx, r_dy;
    logic [CW-1:0]                 n_cur_x, n_cur_y, n_tgt_x, n_tgt_y, n_dx, n_dy;
    logic                          r_xneg, r_yneg, n_xneg, n_yneg;
    logic signed [EW-1:0]          r_err, n_err;
    logic [bres_pkg::COLOR_W-1:0]  r_color, n_color;
    logic                          r_active, n_active;

    logic signed [EW:0]   w_e2, w_ndy, w_pdx;
    logic signed [EW-1:0] w_dx_e, w_dy_e;
    logic                 w_take_x, w_take_y, w_fin;
    logic [CW-1:0]        w_ldx, w_ldy;

    always_comb begin
        // load setup
        w_ldx = (i_req.end_x > i_req.start_x) ? i_req.end_x - i_req.start_x
                                              : i_req.start_x - i_req.end_x;
        w_ldy = (i_req.end_y > i_req.start_y) ? i_req.end_y - i_req.start_y
                                              : i_req.start_y - i_req.end_y;

        // step decision on the stored error term
        w_e2     = $signed({r_err, 1'b0});
        w_ndy    = -$signed({{(EW + 1 - CW){1'b0}}, r_dy});
        w_pdx    = $signed({{(EW + 1 - CW){1'b0}}, r_dx});
        w_dx_e   = $signed({{(EW - CW){1'b0}}, r_dx});
        w_dy_e   = $signed({{(EW - CW){1'b0}}, r_dy});
        w_take_x = w_e2 > w_ndy;
        w_take_y = w_e2 < w_pdx;

        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_tgt_x  = r_tgt_x;
        n_tgt_y  = r_tgt_y;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_xneg   = r_xneg;
        n_yneg   = r_yneg;
        n_err    = r_err;
        n_color  = r_color;
        n_active = r_active;

        if (i_req.req_type == bres_pkg::REQ_LOAD) begin
            n_cur_x = i_req.start_x;
            n_cur_y = i_req.start_y;
            n_tgt_x = i_req.end_x;
            n_tgt_y = i_req.end_y;
            n_dx    = w_ldx;
            n_dy    = w_ldy;
            n_xneg  = !(i_req.start_x < i_req.end_x);
            n_yneg  = !(i_req.start_y < i_req.end_y);
            n_err   = $signed({{(EW - CW){1'b0}}, w_ldx})
                    - $signed({{(EW - CW){1'b0}}, w_ldy});
            n_color = i_req.pen_color;
        end else if (r_active) begin
            n_err = r_err - (w_take_x ? w_dy_e : '0) + (w_take_y ? w_dx_e : '0);
            if (w_take_x) begin
                n_cur_x = r_xneg ? r_cur_x - CW'(1) : r_cur_x + CW'(1);
            end
            if (w_take_y) begin
                n_cur_y = r_yneg ? r_cur_y - CW'(1) : r_cur_y + CW'(1);
            end
        end

        w_fin = (n_cur_x == n_tgt_x) && (n_cur_y == n_tgt_y);

        if (i_req.req_type == bres_pkg::REQ_LOAD || r_active) begin
            n_active          = !w_fin;
            o_pix.valid_res   = 1'b1;
            o_pix.pixel_x     = n_cur_x;
            o_pix.pixel_y     = n_cur_y;
            o_pix.pixel_color = n_color;
            o_pix.last        = w_fin;
        end else begin
            o_pix = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_xneg   <= 1'b0;
            r_yneg   <= 1'b0;
            r_err    <= '0;
            r_color  <= '0;
            r_active <= 1'b0;
        end else if (i_update) begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_tgt_x  <= n_tgt_x;
            r_tgt_y  <= n_tgt_y;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_xneg   <= n_xneg;
            r_yneg   <= n_yneg;
            r_err    <= n_err;
            r_color  <= n_color;
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire

### rtl/bres_addr.sv
// planar frame buffer addressing: byte index, msb-first bit mask, off-screen flag
// depends on bres_pkg for geometry constants and the pixel struct
`timescale 1ns / 1ps
`default_nettype none

module bres_addr (
    input  wire bres_pkg::t_pix            i_pix,
    output logic [bres_pkg::BIDX_W-1:0]    o_byte_index,
    output logic [bres_pkg::MASK_W-1:0]    o_bit_mask,
    output logic                           o_off_screen
);

    localparam int PW = bres_pkg::PROD_W;
    localparam int CW = bres_pkg::COORD_W;

    logic [PW-1:0] w_row_base;
    logic [PW-1:0] w_sum;

    always_comb begin
        w_row_base   = {{(PW - CW){1'b0}}, i_pix.pixel_y} * PW'(bres_pkg::BYTES_PER_ROW);
        w_sum        = w_row_base
                     + {{(PW - CW){1'b0}}, i_pix.pixel_x >> bres_pkg::BITSEL_W};
        // index wraps to 16 bits
        o_byte_index = w_sum[bres_pkg::BIDX_W-1:0];
        o_bit_mask   = i_pix.valid_res
                     ? (bres_pkg::MASK_MSB >> i_pix.pixel_x[bres_pkg::BITSEL_W-1:0])
                     : '0;
        o_off_screen = ({1'b0, i_pix.pixel_x} >= bres_pkg::X_LIMIT)
                    || ({1'b0, i_pix.pixel_y} >= bres_pkg::Y_LIMIT);
    end

endmodule

`default_nettype wire
